// File: rtl/core/assert_macros.svh
// Assertion macros for the button event detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BED_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the check must hold at the next clock edge.
`define BED_ASSERT_NEXT(lbl, trig, check, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (check)) else $error(msg);

`endif

// File: rtl/core/bed_pkg.sv
// Types and constants shared by the button event detector modules.
`timescale 1ns / 1ps

package bed_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned MaxEv   = 6;
  localparam int unsigned EvCntW  = $clog2(MaxEv + 1);
  localparam int unsigned CfgIdxW = 2;

  // Event codes as seen on the result port.
  typedef enum logic [3:0] {
    EV_PRESSED      = 4'd0,
    EV_CHANGED      = 4'd1,
    EV_PRESSING     = 4'd2,
    EV_LONG         = 4'd3,
    EV_REPEAT       = 4'd4,
    EV_DOUBLE       = 4'd5,
    EV_LONG_RELEASE = 4'd6,
    EV_SHORT        = 4'd7,
    EV_CLICK        = 4'd8,
    EV_RELEASED     = 4'd9
  } event_t;

  // Button tracking mode.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_LONG    = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE = 2'd0,
    REG_LONG   = 2'd1,
    REG_REPEAT = 2'd2,
    REG_DOUBLE = 2'd3
  } cfg_reg_t;

  // Events produced by one poll, in order, plus how many are valid.
  typedef struct packed {
    logic [EvCntW-1:0]    count;
    event_t [MaxEv-1:0]   list;
  } ev_list_t;

endpackage

// File: rtl/core/bed_core.sv
// Poll evaluation: configuration, button state and the per-poll event list.
`timescale 1ns / 1ps

module bed_core import bed_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data,
  input  logic               step,
  input  logic               pressed,
  input  logic [TickW-1:0]   now,
  output ev_list_t           evl
);

  logic             enable;
  logic [TickW-1:0] long_press_ticks;
  logic [TickW-1:0] repeat_ticks;
  logic [TickW-1:0] double_click_ticks;

  mode_t            button_mode, button_mode_next;
  logic             long_latched, long_latched_next;
  logic [TickW-1:0] press_time, press_time_next;
  logic [TickW-1:0] long_time, long_time_next;
  logic [TickW-1:0] release_time, release_time_next;

  logic             start;
  logic             active;
  logic             long_hit;
  logic             repeat_hit;
  logic             double_hit;
  logic             short_hit;
  logic [TickW-1:0] press_el;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b1;
      long_press_ticks   <= TickW'(1000);
      repeat_ticks       <= TickW'(100);
      double_click_ticks <= TickW'(300);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE: enable             <= cfg_data[0];
        REG_LONG:   long_press_ticks   <= cfg_data;
        REG_REPEAT: repeat_ticks       <= cfg_data;
        REG_DOUBLE: double_click_ticks <= cfg_data;
      endcase
    end
  end

  // A new press restarts the hold timer on this same poll.
  assign start      = enable && pressed && (button_mode == MODE_IDLE);
  assign active     = enable && (start || (button_mode != MODE_IDLE));
  assign press_el   = now - (start ? now : press_time);
  assign long_hit   = press_el >= long_press_ticks;
  assign repeat_hit = (now - long_time) >= repeat_ticks;
  assign double_hit = (now - release_time) < double_click_ticks;
  assign short_hit  = press_el < long_press_ticks;

  always_comb begin
    button_mode_next  = button_mode;
    long_latched_next = long_latched;
    press_time_next   = press_time;
    long_time_next    = long_time;
    release_time_next = release_time;
    if (start) begin
      button_mode_next = MODE_PRESSED;
      press_time_next  = now;
    end
    if (active) begin
      if (pressed) begin
        if (long_hit) begin
          button_mode_next = MODE_LONG;
          if (!long_latched) begin
            long_time_next    = now;
            long_latched_next = 1'b1;
          end else if (repeat_hit) begin
            long_time_next = now;
          end
        end
      end else begin
        button_mode_next  = MODE_IDLE;
        long_latched_next = 1'b0;
        release_time_next = now;
      end
    end
  end

  // Events are appended in the order they occur.
  always_comb begin
    evl = '0;
    if (start) begin
      evl.list[evl.count] = EV_PRESSED;
      evl.count           = evl.count + 1'b1;
      evl.list[evl.count] = EV_CHANGED;
      evl.count           = evl.count + 1'b1;
    end
    if (active) begin
      if (pressed) begin
        evl.list[evl.count] = EV_PRESSING;
        evl.count           = evl.count + 1'b1;
        if (long_hit && !long_latched) begin
          evl.list[evl.count] = EV_LONG;
          evl.count           = evl.count + 1'b1;
        end else if (long_hit && repeat_hit) begin
          evl.list[evl.count] = EV_REPEAT;
          evl.count           = evl.count + 1'b1;
        end
      end else begin
        if (double_hit) begin
          evl.list[evl.count] = EV_DOUBLE;
          evl.count           = evl.count + 1'b1;
        end
        if (long_latched) begin
          evl.list[evl.count] = EV_LONG_RELEASE;
          evl.count           = evl.count + 1'b1;
        end
        if (short_hit) begin
          evl.list[evl.count] = EV_SHORT;
          evl.count           = evl.count + 1'b1;
        end
        evl.list[evl.count] = EV_CLICK;
        evl.count           = evl.count + 1'b1;
        evl.list[evl.count] = EV_RELEASED;
        evl.count           = evl.count + 1'b1;
        evl.list[evl.count] = EV_CHANGED;
        evl.count           = evl.count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_mode  <= MODE_IDLE;
      long_latched <= 1'b0;
      press_time   <= '0;
      long_time    <= '0;
      release_time <= '0;
    end else if (step) begin
      button_mode  <= button_mode_next;
      long_latched <= long_latched_next;
      press_time   <= press_time_next;
      long_time    <= long_time_next;
      release_time <= release_time_next;
    end
  end

endmodule

// File: rtl/core/bed_serial.sv
// Result buffer that hands out one poll's events one per cycle while out_stall is low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bed_serial import bed_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  ev_list_t  evl,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output event_t    event_res,
  output logic      last
);

  event_t [MaxEv-1:0] buf_list;
  logic [EvCntW-1:0]  buf_cnt;
  logic [EvCntW-1:0]  buf_idx;
  logic               take;

  assign out_valid = (buf_cnt != '0);
  assign event_res = buf_list[buf_idx];
  assign last      = out_valid && (buf_idx == buf_cnt - 1'b1);
  assign take      = out_valid && !out_stall;
  assign free      = !out_valid || (take && last);

  always_ff @(posedge clk) begin
    if (load) begin
      buf_list <= evl.list;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      buf_idx <= '0;
    end else if (load) begin
      buf_cnt <= evl.count;
      buf_idx <= '0;
    end else if (take) begin
      if (last) begin
        buf_cnt <= '0;
        buf_idx <= '0;
      end else begin
        buf_idx <= buf_idx + 1'b1;
      end
    end
  end

  `BED_ASSERT_ALWAYS(a_cnt_range, buf_cnt <= EvCntW'(MaxEv), "event count above maximum")
  `BED_ASSERT_ALWAYS(a_idx_range, !out_valid || (buf_idx < buf_cnt), "event index past count")
  `BED_ASSERT_NEXT(a_drain, take && last && !load, !out_valid, "buffer not empty after last event")

endmodule

// File: rtl/core/button_event_detector_unit.sv
// Button event detector top level: poll register, evaluation and result buffer.
// Path: an accepted request waits in the poll register, then its events go to the result buffer.
// Throughput: one poll per cycle when out_stall is low and each poll yields at most one event.
// Rate limit: the single result buffer drains one event a cycle unless stalled; the next poll loads as it empties.
// Reset: synchronous active-high rst clears control and tracking state and restores register defaults.
`timescale 1ns / 1ps

module button_event_detector_unit import bed_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               pressed,
  input  logic [TickW-1:0]   now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         event_res,
  output logic               last
);

  // Poll register: holds one accepted request until the result buffer
  // can take its event list.
  logic             poll_valid;
  logic             poll_pressed;
  logic [TickW-1:0] poll_now;

  logic     free;
  logic     step;
  logic     accept;
  ev_list_t evl;
  event_t   ev_code;

  // The poll is evaluated and its state committed in the cycle it moves
  // into the result buffer; polls that yield no events move just the same.
  assign step     = poll_valid && free;
  assign in_stall = poll_valid && !free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (accept) begin
      poll_valid <= 1'b1;
    end else if (step) begin
      poll_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      poll_pressed <= pressed;
      poll_now     <= now;
    end
  end

  bed_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .pressed   (poll_pressed),
    .now       (poll_now),
    .evl       (evl)
  );

  // Result buffer; it reports free when empty or when its final event
  // is being taken, so a waiting poll loads without a bubble.
  bed_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .evl       (evl),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (ev_code),
    .last      (last)
  );

  assign event_res = ev_code;

endmodule
